>>> hdl/sdpp_pkg.sv
// Shared types, status codes and header offsets for the sACN data packet parser.
// No dependencies; used by every module of the block.
package sdpp_pkg;

  // Channel limit, queue depth and derived pointer width
  localparam int unsigned MaxChannels = 512;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  // Result kinds
  localparam logic KindChannel = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Summary status codes
  localparam logic [3:0] StOk        = 4'd0;
  localparam logic [3:0] StShort     = 4'd1;
  localparam logic [3:0] StPreamble  = 4'd2;
  localparam logic [3:0] StPostamble = 4'd3;
  localparam logic [3:0] StPktId     = 4'd4;
  localparam logic [3:0] StRootVec   = 4'd5;
  localparam logic [3:0] StFrameVec  = 4'd6;
  localparam logic [3:0] StDmpVec    = 4'd7;
  localparam logic [3:0] StCount     = 4'd8;
  localparam logic [3:0] StTrunc     = 4'd9;

  // Byte offsets inside the packet
  localparam logic [10:0] PosPreamble  = 11'd1;
  localparam logic [10:0] PosPostamble = 11'd3;
  localparam logic [10:0] PosIdFirst   = 11'd4;
  localparam logic [10:0] PosIdLast    = 11'd15;
  localparam logic [10:0] PosRootVec   = 11'd21;
  localparam logic [10:0] PosFrameVec  = 11'd43;
  localparam logic [10:0] PosPriority  = 11'd108;
  localparam logic [10:0] PosSequence  = 11'd111;
  localparam logic [10:0] PosUniverse  = 11'd114;
  localparam logic [10:0] PosDmpVec    = 11'd117;
  localparam logic [10:0] PosCount     = 11'd124;
  localparam logic [10:0] DataStart    = 11'd126;
  localparam logic [10:0] PosMax       = 11'd2047;

  // Expected header values
  localparam logic [15:0] Preamble  = 16'h0010;
  localparam logic [15:0] Postamble = 16'h0000;
  localparam logic [31:0] RootVec   = 32'h0000_0004;
  localparam logic [31:0] FrameVec  = 32'h0000_0002;
  localparam logic [7:0]  DmpVec    = 8'h02;

  // One queue entry: up to one channel result and one summary result
  typedef struct packed {
    logic        has_chan;
    logic [8:0]  chan_index;
    logic [7:0]  chan_value;
    logic        has_sum;
    logic [3:0]  status;
    logic [15:0] universe;
    logic [7:0]  priority_res;
    logic [7:0]  sequence_res;
    logic [9:0]  channel_count;
  } entry_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Packet identifier "ASC-E1.17" and three zero bytes
  function automatic logic [7:0] ident_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h41;
      4'd1:    val = 8'h53;
      4'd2:    val = 8'h43;
      4'd3:    val = 8'h2D;
      4'd4:    val = 8'h45;
      4'd5:    val = 8'h31;
      4'd6:    val = 8'h2E;
      4'd7:    val = 8'h31;
      4'd8:    val = 8'h37;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

>>> hdl/sdpp_if.sv
// Valid/ready channel interfaces for packet bytes and parser results.
// Depends on nothing; used by the front, back and top level.
interface sdpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface sdpp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [8:0]  channel_index;
  logic [7:0]  channel_value;
  logic [3:0]  status;
  logic [15:0] universe;
  logic [7:0]  priority_res;
  logic [7:0]  sequence_res;
  logic [9:0]  channel_count;
  logic        last_result;

  modport source (output valid, output kind, output channel_index, output channel_value,
                  output status, output universe, output priority_res,
                  output sequence_res, output channel_count, output last_result,
                  input ready);
  modport sink   (input valid, input kind, input channel_index, input channel_value,
                  input status, input universe, input priority_res,
                  input sequence_res, input channel_count, input last_result,
                  output ready);
endinterface

>>> hdl/sdpp_front.sv
// Front part: accepts packet bytes, runs header checks, captures fields and
// builds queue entries. Depends on sdpp_pkg and sdpp_byte_if.
module sdpp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sdpp_byte_if.sink              byte_i,
  input  sdpp_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output sdpp_pkg::entry_t       entry_o
);

  logic [10:0] pos_q, pos_d;
  logic [3:0]  err_q, err_d;
  logic [15:0] univ_q, univ_d;
  logic [7:0]  prio_q, prio_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] pc_q, pc_d;
  logic [31:0] ws_q, ws_d;

  logic        accept;
  logic        last;
  logic [7:0]  b;
  logic [3:0]  err_code;
  logic [15:0] count_hw;
  logic [10:0] data_off;
  logic        chan_hit;
  logic [3:0]  sum_status;
  logic [9:0]  sum_count;

  assign byte_i.ready = !q_status_i.full;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.data_byte;
  assign last         = byte_i.end_of_packet;

  // Header checks and field captures at fixed offsets
  always_comb begin
    ws_d     = {ws_q[23:0], b};
    count_hw = {ws_q[7:0], b};
    err_code = sdpp_pkg::StOk;
    if (pos_q == sdpp_pkg::PosPreamble && ws_d[15:0] != sdpp_pkg::Preamble) begin
      err_code = sdpp_pkg::StPreamble;
    end
    if (pos_q == sdpp_pkg::PosPostamble && ws_d[15:0] != sdpp_pkg::Postamble) begin
      err_code = sdpp_pkg::StPostamble;
    end
    if (pos_q >= sdpp_pkg::PosIdFirst && pos_q <= sdpp_pkg::PosIdLast &&
        b != sdpp_pkg::ident_byte(4'(pos_q - sdpp_pkg::PosIdFirst))) begin
      err_code = sdpp_pkg::StPktId;
    end
    if (pos_q == sdpp_pkg::PosRootVec && ws_d != sdpp_pkg::RootVec) begin
      err_code = sdpp_pkg::StRootVec;
    end
    if (pos_q == sdpp_pkg::PosFrameVec && ws_d != sdpp_pkg::FrameVec) begin
      err_code = sdpp_pkg::StFrameVec;
    end
    if (pos_q == sdpp_pkg::PosDmpVec && b != sdpp_pkg::DmpVec) begin
      err_code = sdpp_pkg::StDmpVec;
    end
    // count of 0 or 1, or count-1 above the channel limit
    if (pos_q == sdpp_pkg::PosCount &&
        (count_hw < 16'd2 || count_hw > 16'(sdpp_pkg::MaxChannels + 1))) begin
      err_code = sdpp_pkg::StCount;
    end

    err_d  = (err_q == sdpp_pkg::StOk) ? err_code : err_q;
    prio_d = (pos_q == sdpp_pkg::PosPriority) ? b : prio_q;
    seq_d  = (pos_q == sdpp_pkg::PosSequence) ? b : seq_q;
    univ_d = (pos_q == sdpp_pkg::PosUniverse) ? ws_d[15:0] : univ_q;
    pc_d   = (pos_q == sdpp_pkg::PosCount) ? count_hw : pc_q;
    pos_d  = (pos_q == sdpp_pkg::PosMax) ? pos_q : pos_q + 11'd1;
  end

  // Channel result: no error so far, so the count is known to be 2..limit+1
  assign data_off = pos_q - sdpp_pkg::DataStart;
  assign chan_hit = pos_q >= sdpp_pkg::DataStart && err_q == sdpp_pkg::StOk &&
                    {5'd0, data_off} < (pc_q - 16'd1);

  // Packet summary
  always_comb begin
    sum_status = err_q;
    sum_count  = 10'd0;
    if (pos_q < sdpp_pkg::DataStart) begin
      sum_status = sdpp_pkg::StShort;
    end else if (err_q == sdpp_pkg::StOk) begin
      sum_count = 10'(pc_q - 16'd1);
      // 126 + count > pos + 1
      if ({2'd0, sum_count} + 12'd125 > {1'b0, pos_q}) begin
        sum_status = sdpp_pkg::StTrunc;
      end
    end
  end

  // Queue entry; a field captured from the final byte itself shows in its summary
  always_comb begin
    entry_o               = '0;
    entry_o.has_chan      = chan_hit;
    entry_o.chan_index    = data_off[8:0];
    entry_o.chan_value    = b;
    entry_o.has_sum       = last;
    entry_o.status        = sum_status;
    entry_o.universe      = univ_d;
    entry_o.priority_res  = prio_d;
    entry_o.sequence_res  = seq_d;
    entry_o.channel_count = sum_count;
  end

  assign push_o = accept && (chan_hit || last);

  // Parser state; cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      err_q  <= sdpp_pkg::StOk;
      univ_q <= '0;
      prio_q <= '0;
      seq_q  <= '0;
      pc_q   <= '0;
      ws_q   <= '0;
    end else if (accept) begin
      if (last) begin
        pos_q  <= '0;
        err_q  <= sdpp_pkg::StOk;
        univ_q <= '0;
        prio_q <= '0;
        seq_q  <= '0;
        pc_q   <= '0;
        ws_q   <= '0;
      end else begin
        pos_q  <= pos_d;
        err_q  <= err_d;
        univ_q <= univ_d;
        prio_q <= prio_d;
        seq_q  <= seq_d;
        pc_q   <= pc_d;
        ws_q   <= ws_d;
      end
    end
  end

endmodule

>>> hdl/sdpp_queue.sv
// Short entry queue between the front and back parts.
// Depends on sdpp_pkg.
module sdpp_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sdpp_pkg::entry_t        entry_i,
  input  logic                    pop_i,
  output sdpp_pkg::entry_t        head_o,
  output sdpp_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = sdpp_pkg::QueuePtrW;

  sdpp_pkg::entry_t mem_q [sdpp_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;

  assign status_o.full  = cnt_q == (PtrW+1)'(sdpp_pkg::QueueDepth);
  assign status_o.empty = cnt_q == '0;
  assign head_o         = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Count tracks pointer distance; no overflow or underflow
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue pop while empty");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q != (PtrW+1)'(sdpp_pkg::QueueDepth) |->
      (wr_ptr_q - rd_ptr_q) == cnt_q[PtrW-1:0])
    else $error("queue count does not match pointers");

endmodule

>>> hdl/sdpp_back.sv
// Back part: turns queue entries into result words through an output register.
// Depends on sdpp_pkg and sdpp_res_if.
module sdpp_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sdpp_pkg::entry_t        head_i,
  input  sdpp_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  sdpp_res_if.source              res_o
);

  logic        valid_q;
  logic        sent_q;
  logic        load;
  logic        emit_chan;
  logic        kind_q;
  logic [8:0]  index_q;
  logic [7:0]  value_q;
  logic [3:0]  status_q;
  logic [15:0] univ_q;
  logic [7:0]  prio_q;
  logic [7:0]  seq_q;
  logic [9:0]  count_q;
  logic        last_q;

  assign load      = (!valid_q || res_o.ready) && !q_status_i.empty;
  assign emit_chan = head_i.has_chan && !sent_q;
  // an entry with both results stays for a second word
  assign pop_o     = load && !(emit_chan && head_i.has_sum);

  // Output valid and per-entry progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sent_q  <= emit_chan && head_i.has_sum;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (emit_chan) begin
        kind_q   <= sdpp_pkg::KindChannel;
        index_q  <= head_i.chan_index;
        value_q  <= head_i.chan_value;
        status_q <= sdpp_pkg::StOk;
        univ_q   <= '0;
        prio_q   <= '0;
        seq_q    <= '0;
        count_q  <= '0;
        last_q   <= !head_i.has_sum;
      end else begin
        kind_q   <= sdpp_pkg::KindSummary;
        index_q  <= '0;
        value_q  <= '0;
        status_q <= head_i.status;
        univ_q   <= head_i.universe;
        prio_q   <= head_i.priority_res;
        seq_q    <= head_i.sequence_res;
        count_q  <= head_i.channel_count;
        last_q   <= 1'b1;
      end
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.kind          = kind_q;
  assign res_o.channel_index = index_q;
  assign res_o.channel_value = value_q;
  assign res_o.status        = status_q;
  assign res_o.universe      = univ_q;
  assign res_o.priority_res  = prio_q;
  assign res_o.sequence_res  = seq_q;
  assign res_o.channel_count = count_q;
  assign res_o.last_result   = last_q;

  // Half-sent entry still waits in the queue for its summary
  a_sent_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q |-> !q_status_i.empty && head_i.has_sum)
    else $error("summary lost after channel word");
  a_chan_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sent_q) |-> valid_q && kind_q == sdpp_pkg::KindChannel && !last_q)
    else $error("channel word of a two-word entry marked last");

endmodule

>>> hdl/sacn_data_packet_parser_unit.sv
// Top level of the sACN (E1.31) data packet parser.
// Depends on sdpp_pkg, sdpp_if, sdpp_front, sdpp_queue and sdpp_back.
//
// Usage:
//   byte_i carries one packet byte per word with end_of_packet on the final
//   byte. res_o carries result words: a channel word (kind 0) for each DMX
//   channel byte of a packet whose header passed, and one summary word
//   (kind 1) on the final byte with the first error, universe, priority,
//   sequence and channel count. last_result marks the last word of a byte.
//   Throughput: one byte per cycle while the queue has room; the final byte of
//   a packet that also carries a channel value gives two words, the channel
//   word and then the summary word. Each result passes through the queue and
//   then the output register, and waits in the queue while the output holds
//   an earlier word.
//   The front accepts bytes while the four-entry queue has room, so bytes
//   keep flowing while a finished word waits; when the receiver stalls the
//   queue fills and byte_i.ready drops.
//   Reset clears the parser state, the queue and the output valid; the block
//   is ready for the first byte of a packet right after reset.
module sacn_data_packet_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdpp_byte_if.sink  byte_i,
  sdpp_res_if.source res_o
);

  logic                    push;
  logic                    pop;
  sdpp_pkg::entry_t        entry;
  sdpp_pkg::entry_t        head;
  sdpp_pkg::queue_status_t q_status;

  sdpp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (entry)
  );

  sdpp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  sdpp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

>>> tb/sv/sacn_data_packet_parser_unit_tb.sv
// Self-checking bench for sacn_data_packet_parser_unit: streams sACN packets as byte words
// and checks every channel and summary word against a built-in parser model.
// Depends on sdpp_pkg, sdpp_if and the block's RTL.
module sacn_data_packet_parser_unit_tb;
  import sdpp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 12;

  // "ASC-E1.17" padded with three zero bytes
  localparam logic [7:0] IdChars [12] = '{8'h41, 8'h53, 8'h43, 8'h2D, 8'h45, 8'h31,
                                          8'h2E, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00};

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } byte_word_t;

  typedef struct packed {
    logic        kind;
    logic [8:0]  chan_index;
    logic [7:0]  chan_value;
    logic [3:0]  status;
    logic [15:0] universe;
    logic [7:0]  prio;
    logic [7:0]  seq;
    logic [9:0]  count;
    logic        last_word;
  } res_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sdpp_byte_if byte_if ();
  sdpp_res_if  res_if ();

  sacn_data_packet_parser_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .res_o  (res_if)
  );

  // Stimulus and expectation stores
  byte_word_t pending_bytes [$];
  res_word_t  expected_words [$];
  logic [7:0] pkt_buf [$];

  // Parser model state
  logic [10:0] pos_q = '0;
  logic [3:0]  fault_q = StOk;
  logic [15:0] universe_q = '0;
  logic [7:0]  prio_q = '0;
  logic [7:0]  seq_q = '0;
  logic [15:0] prop_count_q = '0;
  logic [31:0] shift_q = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int cycles = 0;
  int packets_queued = 0;
  int bytes_queued = 0;
  int chan_checked = 0;
  int sum_checked = 0;
  logic [9:0] statuses_seen = '0;
  byte_word_t next_byte;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.end_of_packet = 1'b0;
    res_if.ready = 1'b0;
  end

  // Keep only the first header fault
  function automatic void note_fault(input logic [3:0] code);
    if (fault_q == StOk) fault_q = code;
  endfunction

  // Advance the parser model by one accepted byte and queue the words it produces
  task automatic parse_byte(input logic [7:0] b, input logic eop);
    logic [10:0] pos;
    int len;
    int chans;
    res_word_t w;
    pos = pos_q;
    shift_q = {shift_q[23:0], b};
    if (pos == PosPreamble && shift_q[15:0] != Preamble) note_fault(StPreamble);
    if (pos == PosPostamble && shift_q[15:0] != Postamble) note_fault(StPostamble);
    if (pos >= PosIdFirst && pos <= PosIdLast && b != IdChars[pos - PosIdFirst])
      note_fault(StPktId);
    if (pos == PosRootVec && shift_q != RootVec) note_fault(StRootVec);
    if (pos == PosFrameVec && shift_q != FrameVec) note_fault(StFrameVec);
    if (pos == PosPriority) prio_q = b;
    if (pos == PosSequence) seq_q = b;
    if (pos == PosUniverse) universe_q = shift_q[15:0];
    if (pos == PosDmpVec && b != DmpVec) note_fault(StDmpVec);
    if (pos == PosCount) begin
      prop_count_q = shift_q[15:0];
      if (prop_count_q < 16'd2 || int'(prop_count_q) - 1 > int'(MaxChannels))
        note_fault(StCount);
    end
    chans = int'(prop_count_q) - 1;

    // Channel data while the header is clean
    if (pos >= DataStart && fault_q == StOk && int'(pos - DataStart) < chans) begin
      w = '0;
      w.kind = KindChannel;
      w.chan_index = 9'(pos - DataStart);
      w.chan_value = b;
      w.last_word = !eop;
      expected_words.push_back(w);
    end

    if (pos != PosMax) pos_q = pos + 11'd1;

    // Packet summary, then back to the idle state
    if (eop) begin
      len = int'(pos) + 1;
      w = '0;
      w.kind = KindSummary;
      w.last_word = 1'b1;
      if (len < int'(DataStart) + 1) begin
        w.status = StShort;
      end else begin
        w.status = fault_q;
        if (fault_q == StOk) begin
          w.count = 10'(chans);
          if (int'(DataStart) + chans > len) w.status = StTrunc;
        end
      end
      w.universe = universe_q;
      w.prio = prio_q;
      w.seq = seq_q;
      statuses_seen[w.status] = 1'b1;
      expected_words.push_back(w);
      pos_q = '0;
      fault_q = StOk;
      universe_q = '0;
      prio_q = '0;
      seq_q = '0;
      prop_count_q = '0;
      shift_q = '0;
    end
  endtask

  // Byte driver; the model sees each byte as it is accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready)
        parse_byte(byte_if.data_byte, byte_if.end_of_packet);
      if (!byte_if.valid || byte_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          byte_if.valid <= 1'b1;
          byte_if.data_byte <= next_byte.data;
          byte_if.end_of_packet <= next_byte.eop;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Names of the fields that differ
  function automatic string diff_fields(input res_word_t exp_w, input res_word_t got_w);
    string s;
    s = "";
    if (got_w.kind !== exp_w.kind) s = {s, " kind"};
    if (got_w.chan_index !== exp_w.chan_index) s = {s, " channel_index"};
    if (got_w.chan_value !== exp_w.chan_value) s = {s, " channel_value"};
    if (got_w.status !== exp_w.status) s = {s, " status"};
    if (got_w.universe !== exp_w.universe) s = {s, " universe"};
    if (got_w.prio !== exp_w.prio) s = {s, " priority_res"};
    if (got_w.seq !== exp_w.seq) s = {s, " sequence_res"};
    if (got_w.count !== exp_w.count) s = {s, " channel_count"};
    if (got_w.last_word !== exp_w.last_word) s = {s, " last_result"};
    return s;
  endfunction

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin
    res_word_t got_w;
    res_word_t exp_w;
    string bad;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_w = '{res_if.kind, res_if.channel_index, res_if.channel_value, res_if.status,
                  res_if.universe, res_if.priority_res, res_if.sequence_res,
                  res_if.channel_count, res_if.last_result};
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word %p", $time, got_w);
        end else begin
          exp_w = expected_words.pop_front();
          bad = diff_fields(exp_w, got_w);
          if (bad != "") begin
            fail_count++;
            $display("%0t: mismatch in%s: expected %p, actual %p", $time, bad, exp_w, got_w);
          end
          if (exp_w.kind == KindSummary) sum_checked++;
          else chan_checked++;
        end
      end
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d bytes and %0d words outstanding", $time,
               pending_bytes.size(), expected_words.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Clean header with the given property count, no channel data yet
  task automatic make_header(input logic [15:0] pc);
    pkt_buf.delete();
    repeat (int'(DataStart)) pkt_buf.push_back(8'($urandom));
    pkt_buf[0] = Preamble[15:8];
    pkt_buf[1] = Preamble[7:0];
    pkt_buf[2] = Postamble[15:8];
    pkt_buf[3] = Postamble[7:0];
    for (int i = 0; i < 12; i++) pkt_buf[4 + i] = IdChars[i];
    for (int i = 0; i < 4; i++) begin
      pkt_buf[18 + i] = RootVec[31 - 8 * i -: 8];
      pkt_buf[40 + i] = FrameVec[31 - 8 * i -: 8];
    end
    pkt_buf[117] = DmpVec;
    pkt_buf[123] = pc[15:8];
    pkt_buf[124] = pc[7:0];
  endtask

  task automatic add_data(input int n);
    repeat (n) pkt_buf.push_back(8'($urandom));
  endtask

  // Move the built packet into the driver queue, flag on its last byte
  task automatic queue_packet();
    byte_word_t bw;
    for (int i = 0; i < pkt_buf.size(); i++) begin
      bw.data = pkt_buf[i];
      bw.eop = (i == pkt_buf.size() - 1);
      pending_bytes.push_back(bw);
    end
    packets_queued++;
    bytes_queued += pkt_buf.size();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_if.valid || expected_words.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int ch;
    int r;
    int off;
    int start;
    logic [15:0] pc;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed packets, no idling
    pkt_buf.delete();
    pkt_buf.push_back(8'hFF);
    queue_packet();
    // full header but one byte short of the minimum
    make_header(16'd2);
    queue_packet();
    // short packet with a preamble fault still reports too short
    make_header(16'd2);
    pkt_buf[1] = 8'h11;
    while (pkt_buf.size() > 60) void'(pkt_buf.pop_back());
    queue_packet();
    // one channel: channel word and summary from the same byte
    make_header(16'd2);
    add_data(1);
    queue_packet();
    // full universe with extreme levels
    make_header(16'(MaxChannels + 1));
    for (int i = 0; i < int'(MaxChannels); i++) pkt_buf.push_back(i[0] ? 8'hFF : 8'h00);
    queue_packet();
    // property counts just outside the legal range and the largest count
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: pc = 16'd0;
        1: pc = 16'd1;
        2: pc = 16'(MaxChannels + 2);
        default: pc = 16'hFFFF;
      endcase
      make_header(pc);
      add_data(4);
      queue_packet();
    end
    // one fault per header check other than the count
    for (int i = 0; i < 6; i++) begin
      make_header(16'd5);
      add_data(4);
      case (i)
        0: pkt_buf[0] = pkt_buf[0] ^ 8'h80;
        1: pkt_buf[3] = 8'h01;
        2: pkt_buf[15] = 8'h20;
        3: pkt_buf[18] = 8'hFF;
        4: pkt_buf[43] = 8'h03;
        default: pkt_buf[117] = 8'h00;
      endcase
      queue_packet();
    end
    // two faults: the earlier offset wins
    make_header(16'd5);
    add_data(4);
    pkt_buf[2] = 8'h40;
    pkt_buf[117] = 8'hFF;
    queue_packet();
    // truncated data
    make_header(16'd11);
    add_data(5);
    queue_packet();
    make_header(16'(MaxChannels + 1));
    add_data(1);
    queue_packet();
    // trailing bytes past the channel data
    make_header(16'd4);
    add_data(53);
    queue_packet();
    // long enough for the position counter to saturate
    make_header(16'd3);
    add_data(2100 - int'(DataStart));
    queue_packet();
    // all-zero and all-one packets
    pkt_buf.delete();
    repeat (130) pkt_buf.push_back(8'h00);
    queue_packet();
    pkt_buf.delete();
    repeat (130) pkt_buf.push_back(8'hFF);
    queue_packet();
    wait_drained();

    // Random packets under each handshake phase
    for (int p = 0; p < 4; p++) begin
      @(negedge clk_i);
      case (p)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 56; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 56; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      start = bytes_queued;
      while (bytes_queued - start < 750) begin
        ch = ($urandom_range(15) == 0) ? $urandom_range(1, MaxChannels) : $urandom_range(1, 24);
        make_header(16'(ch + 1));
        add_data(ch);
        r = $urandom_range(99);
        if (r < 60) begin
          // well formed, sometimes with a tail
          if ($urandom_range(3) == 0) add_data($urandom_range(1, 20));
        end else if (r < 70) begin
          repeat ($urandom_range(1, ch)) void'(pkt_buf.pop_back());
        end else if (r < 85) begin
          // one or two header faults
          repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(5))
              0: off = $urandom_range(0, 3);
              1: off = $urandom_range(4, 15);
              2: off = $urandom_range(18, 21);
              3: off = $urandom_range(40, 43);
              4: off = 117;
              default: off = $urandom_range(123, 124);
            endcase
            pkt_buf[off] = pkt_buf[off] ^ 8'($urandom_range(1, 255));
          end
        end else if (r < 92) begin
          case ($urandom_range(2))
            0: pc = 16'd0;
            1: pc = 16'd1;
            default: pc = 16'($urandom_range(MaxChannels + 2, 65535));
          endcase
          pkt_buf[123] = pc[15:8];
          pkt_buf[124] = pc[7:0];
        end else if (r < 96) begin
          while (pkt_buf.size() > 1 && pkt_buf.size() > $urandom_range(1, 126))
            void'(pkt_buf.pop_back());
        end else begin
          pkt_buf.delete();
          add_data($urandom_range(1, 140));
        end
        queue_packet();
      end
      wait_drained();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (expected_words.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
    end

    $display("Covered %0d packets (%0d bytes): %0d channel words, %0d summaries checked",
             packets_queued, bytes_queued, chan_checked, sum_checked);
    $display("Status codes reached (bit per code): %b, under four idle/stall phases",
             statuses_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sdpp_pkg.sv
hdl/sdpp_if.sv
hdl/sdpp_front.sv
hdl/sdpp_queue.sv
hdl/sdpp_back.sv
hdl/sacn_data_packet_parser_unit.sv
tb/sv/sacn_data_packet_parser_unit_tb.sv
